FILE: rtl/vss_pkg.sv
// Shared types and constants for the version slot store.
// No dependencies; imported by every module of the block.
`default_nettype none

package vss_pkg;

  localparam int unsigned VER_W        = 31;
  localparam int unsigned LEN_W        = 16;
  localparam int unsigned PAY_FIELD_W  = 64;
  localparam int unsigned CNT_FIELD_W  = 4;
  localparam int unsigned IN_TDATA_W   = 112;
  localparam int unsigned OUT_TDATA_W  = 120;

  typedef enum logic {
    KIND_ADD = 1'b0,
    KIND_GET = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_SCAN,
    ST_DONE
  } state_t;

  // running scan record handed from cell to cell
  typedef struct packed {
    logic             tok;
    logic             match_hit;
    logic             empty_hit;
    logic             old_hit;
    logic [VER_W-1:0] old_ver;
    logic             best_hit;
    logic [VER_W-1:0] best_ver;
    logic [LEN_W-1:0] best_len;
  } scan_t;

  typedef struct packed {
    logic             en;
    logic [VER_W-1:0] ver;
    logic [LEN_W-1:0] len;
  } wr_t;

endpackage

`default_nettype wire

FILE: rtl/vss_cell.sv
// One slot of the version store plus its stage of the scan chain.
// Depends on vss_pkg.
`default_nettype none

module vss_cell #(
  parameter int unsigned IDX_W        = 3,
  parameter int unsigned PAYLOAD_BITS = 64,
  parameter int unsigned CELL_IDX     = 0
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [vss_pkg::VER_W-1:0]  query_ver,
  input  wire vss_pkg::scan_t             scan_in,
  input  wire logic [IDX_W-1:0]           match_idx_in,
  input  wire logic [IDX_W-1:0]           empty_idx_in,
  input  wire logic [IDX_W-1:0]           old_idx_in,
  input  wire logic [PAYLOAD_BITS-1:0]    best_pay_in,
  input  wire vss_pkg::wr_t               wr,
  input  wire logic [IDX_W-1:0]           wr_idx,
  input  wire logic [PAYLOAD_BITS-1:0]    wr_pay,
  output vss_pkg::scan_t                  scan_out,
  output logic [IDX_W-1:0]                match_idx_out,
  output logic [IDX_W-1:0]                empty_idx_out,
  output logic [IDX_W-1:0]                old_idx_out,
  output logic [PAYLOAD_BITS-1:0]         best_pay_out
);
  import vss_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic                    valid_r;
  logic [VER_W-1:0]        ver_r;
  logic [PAYLOAD_BITS-1:0] pay_r;
  logic [LEN_W-1:0]        len_r;

  logic                    tok_r;
  scan_t                   acc_r, acc_nxt;
  logic [IDX_W-1:0]        match_idx_r, match_idx_nxt;
  logic [IDX_W-1:0]        empty_idx_r, empty_idx_nxt;
  logic [IDX_W-1:0]        old_idx_r, old_idx_nxt;
  logic [PAYLOAD_BITS-1:0] best_pay_r, best_pay_nxt;

  logic wr_hit;
  assign wr_hit = wr.en && (wr_idx == MY_IDX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (wr_hit) begin
      valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_hit) begin
      ver_r <= wr.ver;
      pay_r <= wr_pay;
      len_r <= wr.len;
    end
  end

  always_comb begin
    acc_nxt       = scan_in;
    match_idx_nxt = match_idx_in;
    empty_idx_nxt = empty_idx_in;
    old_idx_nxt   = old_idx_in;
    best_pay_nxt  = best_pay_in;
    // first matching version wins
    if (valid_r && (ver_r == query_ver) && !scan_in.match_hit) begin
      acc_nxt.match_hit = 1'b1;
      match_idx_nxt     = MY_IDX;
    end
    // last empty slot wins
    if (!valid_r) begin
      acc_nxt.empty_hit = 1'b1;
      empty_idx_nxt     = MY_IDX;
    end
    // oldest tracked only until an empty slot has been seen
    if (valid_r && !scan_in.empty_hit &&
        (!scan_in.old_hit || (ver_r < scan_in.old_ver))) begin
      acc_nxt.old_hit = 1'b1;
      acc_nxt.old_ver = ver_r;
      old_idx_nxt     = MY_IDX;
    end
    // newest version not above the query
    if (valid_r && (ver_r <= query_ver) &&
        (!scan_in.best_hit || (ver_r > scan_in.best_ver))) begin
      acc_nxt.best_hit = 1'b1;
      acc_nxt.best_ver = ver_r;
      acc_nxt.best_len = len_r;
      best_pay_nxt     = pay_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
    end else begin
      tok_r <= scan_in.tok;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_in.tok) begin
      acc_r       <= acc_nxt;
      match_idx_r <= match_idx_nxt;
      empty_idx_r <= empty_idx_nxt;
      old_idx_r   <= old_idx_nxt;
      best_pay_r  <= best_pay_nxt;
    end
  end

  always_comb begin
    scan_out     = acc_r;
    scan_out.tok = tok_r;
  end

  assign match_idx_out = match_idx_r;
  assign empty_idx_out = empty_idx_r;
  assign old_idx_out   = old_idx_r;
  assign best_pay_out  = best_pay_r;

endmodule

`default_nettype wire

FILE: rtl/vss_ctrl.sv
// Sequencer, item and result registers and occupancy count.
// Depends on vss_pkg; drives the head of the cell chain and reads its tail.
`default_nettype none

module vss_ctrl #(
  parameter int unsigned SLOTS        = 8,
  parameter int unsigned IDX_W        = 3,
  parameter int unsigned PAYLOAD_BITS = 64
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [vss_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  wire logic [0:0]                       in_tuser,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [vss_pkg::OUT_TDATA_W-1:0]       out_tdata,
  output logic [0:0]                            out_tuser,
  output logic [vss_pkg::VER_W-1:0]             query_ver,
  output vss_pkg::scan_t                        scan_head,
  input  wire vss_pkg::scan_t                   scan_tail,
  input  wire logic [IDX_W-1:0]                 match_idx,
  input  wire logic [IDX_W-1:0]                 empty_idx,
  input  wire logic [IDX_W-1:0]                 old_idx,
  input  wire logic [PAYLOAD_BITS-1:0]          best_pay,
  output vss_pkg::wr_t                          wr,
  output logic [IDX_W-1:0]                      wr_idx,
  output logic [PAYLOAD_BITS-1:0]               wr_pay
);
  import vss_pkg::*;

  localparam int unsigned CNT_W = $clog2(SLOTS + 1);

  state_t                  state_r, state_nxt;
  kind_t                   item_kind_r;
  logic [VER_W-1:0]        item_ver_r;
  logic [PAYLOAD_BITS-1:0] item_pay_r;
  logic [LEN_W-1:0]        item_len_r;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic                    out_found_r;
  logic [VER_W-1:0]        out_ver_r;
  logic [PAY_FIELD_W-1:0]  out_pay_r;
  logic [LEN_W-1:0]        out_len_r;
  logic [CNT_FIELD_W-1:0]  out_cnt_r;

  logic                    accept, out_free, load, is_add, new_slot;
  logic                    res_found;
  logic [VER_W-1:0]        res_ver;
  logic [PAY_FIELD_W-1:0]  res_pay;
  logic [LEN_W-1:0]        res_len;
  logic [CNT_W+CNT_FIELD_W-1:0] cnt_ext;

  assign accept   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign is_add   = (item_kind_r == KIND_ADD);
  assign new_slot = !scan_tail.match_hit && scan_tail.empty_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    load      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) state_nxt = ST_LAUNCH;
      end
      ST_LAUNCH: begin
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_tail.tok) begin
          if (out_free) begin
            load      = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          load      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_kind_r <= kind_t'(in_tuser[0]);
      item_ver_r  <= in_tdata[VER_W-1:0];
      item_pay_r  <= in_tdata[VER_W +: PAYLOAD_BITS];
      item_len_r  <= in_tdata[VER_W+PAY_FIELD_W +: LEN_W];
    end
  end

  always_comb begin
    scan_head     = '0;
    scan_head.tok = (state_r == ST_LAUNCH);
  end
  assign query_ver = item_ver_r;

  always_comb begin
    wr.en  = load && is_add;
    wr.ver = item_ver_r;
    wr.len = item_len_r;
    wr_pay = item_pay_r;
    if (scan_tail.match_hit) begin
      wr_idx = match_idx;
    end else if (scan_tail.empty_hit) begin
      wr_idx = empty_idx;
    end else begin
      wr_idx = old_idx;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (load && is_add && new_slot) cnt_nxt = cnt_r + CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_comb begin
    res_found = 1'b1;
    res_ver   = '0;
    res_pay   = '0;
    res_len   = '0;
    if (!is_add) begin
      res_found = scan_tail.best_hit;
      if (scan_tail.best_hit) begin
        res_ver                    = scan_tail.best_ver;
        res_pay[PAYLOAD_BITS-1:0]  = best_pay;
        res_len                    = scan_tail.best_len;
      end
    end
    cnt_ext = {{CNT_FIELD_W{1'b0}}, cnt_nxt};
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_found_r <= res_found;
      out_ver_r   <= res_ver;
      out_pay_r   <= res_pay;
      out_len_r   <= res_len;
      out_cnt_r   <= cnt_ext[CNT_FIELD_W-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_found_r;
  assign out_tdata  = {{(OUT_TDATA_W-VER_W-PAY_FIELD_W-LEN_W-CNT_FIELD_W){1'b0}},
                       out_cnt_r, out_len_r, out_pay_r, out_ver_r};

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(SLOTS))
    else $error("occupancy count above slot total");

  a_tok_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    scan_tail.tok |-> (state_r == ST_SCAN))
    else $error("scan finished outside scan state");

  a_get_not_above: assert property (@(posedge clk) disable iff (!rst_n)
    (load && !is_add && scan_tail.best_hit) |-> (scan_tail.best_ver <= item_ver_r))
    else $error("get returned a version above the query");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (load && is_add && new_slot) |=> (cnt_r == $past(cnt_r) + CNT_W'(1)))
    else $error("new slot did not raise the count");
`endif

endmodule

`default_nettype wire

FILE: rtl/version_slot_store.sv
// Version slot store: an accepted add or get is held in the item registers,
// the scan token is launched at the head of the chain of slot cells and walks
// it one cell per cycle, and when it reaches the tail the result is loaded
// into the output register; if that register is still full, the load waits
// until it frees. The next word is taken only after the load. The slot write
// of an add happens in the same cycle as the result is loaded. A finished
// result may wait in the output register while the next word is accepted and scanned.
// Depends on vss_pkg, vss_cell and vss_ctrl.
`default_nettype none

module version_slot_store #(
  parameter int unsigned SLOTS        = 8,
  parameter int unsigned PAYLOAD_BITS = 64
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // [30:0] version, [94:31] payload, [110:95] value_length, [111] zero
  input  wire logic [vss_pkg::IN_TDATA_W-1:0]   in_tdata,
  // [0] kind
  input  wire logic [0:0]                       in_tuser,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // [30:0] out_version, [94:31] out_payload, [110:95] out_length,
  // [114:111] entry_count, [119:115] zero
  output logic [vss_pkg::OUT_TDATA_W-1:0]       out_tdata,
  // [0] found
  output logic [0:0]                            out_tuser
);
  import vss_pkg::*;

  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  scan_t                   scan_w      [SLOTS+1];
  logic [IDX_W-1:0]        match_idx_w [SLOTS+1];
  logic [IDX_W-1:0]        empty_idx_w [SLOTS+1];
  logic [IDX_W-1:0]        old_idx_w   [SLOTS+1];
  logic [PAYLOAD_BITS-1:0] best_pay_w  [SLOTS+1];

  logic [VER_W-1:0]        query_ver;
  wr_t                     wr;
  logic [IDX_W-1:0]        wr_idx;
  logic [PAYLOAD_BITS-1:0] wr_pay;

  assign match_idx_w[0] = '0;
  assign empty_idx_w[0] = '0;
  assign old_idx_w[0]   = '0;
  assign best_pay_w[0]  = '0;

  vss_ctrl #(
    .SLOTS        (SLOTS),
    .IDX_W        (IDX_W),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .query_ver  (query_ver),
    .scan_head  (scan_w[0]),
    .scan_tail  (scan_w[SLOTS]),
    .match_idx  (match_idx_w[SLOTS]),
    .empty_idx  (empty_idx_w[SLOTS]),
    .old_idx    (old_idx_w[SLOTS]),
    .best_pay   (best_pay_w[SLOTS]),
    .wr         (wr),
    .wr_idx     (wr_idx),
    .wr_pay     (wr_pay)
  );

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    vss_cell #(
      .IDX_W        (IDX_W),
      .PAYLOAD_BITS (PAYLOAD_BITS),
      .CELL_IDX     (g)
    ) u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .query_ver     (query_ver),
      .scan_in       (scan_w[g]),
      .match_idx_in  (match_idx_w[g]),
      .empty_idx_in  (empty_idx_w[g]),
      .old_idx_in    (old_idx_w[g]),
      .best_pay_in   (best_pay_w[g]),
      .wr            (wr),
      .wr_idx        (wr_idx),
      .wr_pay        (wr_pay),
      .scan_out      (scan_w[g+1]),
      .match_idx_out (match_idx_w[g+1]),
      .empty_idx_out (empty_idx_w[g+1]),
      .old_idx_out   (old_idx_w[g+1]),
      .best_pay_out  (best_pay_w[g+1])
    );
  end

endmodule

`default_nettype wire
